// ----- src/assert_macros.svh -----
// Assertion macros shared by the frame parser RTL.
// Included by the modules that carry concurrent checks; needs no other file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- src/ffcp_pkg.sv -----
// Types and constants of the fixed frame coordinate parser.
// Used by every module of the block; depends on nothing.
package ffcp_pkg;

    localparam int BYTE_W    = 8;
    localparam int POS_W     = 4;
    localparam int COORD_W   = 16;
    localparam int MAG_W     = 15;

    localparam logic [POS_W-1:0]  BODY_LEN    = 4'd10;
    localparam logic [BYTE_W-1:0] HDR_FIRST   = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR_SECOND  = 8'hBB;
    localparam logic [BYTE_W-1:0] TRAILER     = 8'hFF;
    localparam logic [BYTE_W-1:0] QUAD_TWO    = 8'd2;
    localparam logic [BYTE_W-1:0] QUAD_THREE  = 8'd3;
    localparam logic [BYTE_W-1:0] QUAD_FOUR   = 8'd4;
    localparam logic [MAG_W-1:0]  COORD_SCALE = 15'd100;

    // One accepted frame, raw bytes 2 to 9.
    typedef struct packed {
        logic [BYTE_W-1:0] plate_colour;
        logic [BYTE_W-1:0] bottle_colour;
        logic [BYTE_W-1:0] status_code;
        logic [BYTE_W-1:0] quadrant;
        logic [BYTE_W-1:0] x_whole;
        logic [BYTE_W-1:0] x_frac;
        logic [BYTE_W-1:0] y_whole;
        logic [BYTE_W-1:0] y_frac;
    } frame_rec_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_status_t;

endpackage

// ----- src/ffcp_front.sv -----
// Front part: accepts bytes, stores the frame body and checks trailer and header.
// Depends on ffcp_pkg and assert_macros.svh; pushes good frames into ffcp_queue.
`include "assert_macros.svh"

module ffcp_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ffcp_pkg::BYTE_W-1:0] rx_byte,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ffcp_pkg::q_status_t         q_status,
    output logic                        push,
    output ffcp_pkg::frame_rec_t        push_rec
);
    import ffcp_pkg::*;

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [BYTE_W-1:0] store_reg [0:9];
    logic              accept;
    logic              at_trailer;

    assign at_trailer = (pos_reg == BODY_LEN);
    // Only the trailer byte needs queue space; body bytes are always taken.
    assign in_ready   = !at_trailer || !q_status.full;
    assign accept     = in_valid && in_ready;

    assign push = accept && at_trailer && (rx_byte == TRAILER)
                  && (store_reg[0] == HDR_FIRST) && (store_reg[1] == HDR_SECOND);

    assign push_rec.plate_colour  = store_reg[2];
    assign push_rec.bottle_colour = store_reg[3];
    assign push_rec.status_code   = store_reg[4];
    assign push_rec.quadrant      = store_reg[5];
    assign push_rec.x_whole       = store_reg[6];
    assign push_rec.x_frac        = store_reg[7];
    assign push_rec.y_whole       = store_reg[8];
    assign push_rec.y_frac        = store_reg[9];

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (pos_reg < BODY_LEN)
                pos_next = pos_reg + 4'd1;
            else
                pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pos_reg < BODY_LEN))
            store_reg[pos_reg] <= rx_byte;
    end

    `ASSERT_IMPLIES(a_pos_range, clk, rst_n, 1'b1, pos_reg <= BODY_LEN)
    `ASSERT_IMPLIES(a_push_at_trailer, clk, rst_n, push, at_trailer && (rx_byte == TRAILER))

endmodule

// ----- src/ffcp_queue.sv -----
// Short queue of checked frames between the front and back parts.
// Depends on ffcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ffcp_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  ffcp_pkg::frame_rec_t push_rec,
    input  logic                 pop,
    output ffcp_pkg::frame_rec_t head_rec,
    output ffcp_pkg::q_status_t  status
);
    import ffcp_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    frame_rec_t       entry_reg [0:DEPTH-1];
    logic [IDX_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IDX_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_rec         = entry_reg[rd_ptr_reg];
    assign status.not_empty = (count_reg != '0);
    assign status.full      = (count_reg == FULL_CNT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + IDX_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + IDX_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !status.full)
    `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, status.not_empty)

endmodule

// ----- src/ffcp_back.sv -----
// Back part: scales and signs the coordinates and holds the result register.
// Depends on ffcp_pkg and assert_macros.svh; pops frames from ffcp_queue.
`include "assert_macros.svh"

module ffcp_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffcp_pkg::frame_rec_t         head_rec,
    input  ffcp_pkg::q_status_t          q_status,
    output logic                         pop,
    output logic [ffcp_pkg::BYTE_W-1:0]  plate_colour,
    output logic [ffcp_pkg::BYTE_W-1:0]  bottle_colour,
    output logic [ffcp_pkg::BYTE_W-1:0]  status_code,
    output logic [ffcp_pkg::BYTE_W-1:0]  quadrant,
    output logic signed [ffcp_pkg::COORD_W-1:0] x_position,
    output logic signed [ffcp_pkg::COORD_W-1:0] y_position,
    output logic                         out_valid,
    input  logic                         out_ready
);
    import ffcp_pkg::*;

    logic                      out_valid_reg;
    logic [BYTE_W-1:0]         plate_reg, bottle_reg, status_reg, quad_reg;
    logic signed [COORD_W-1:0] x_reg, y_reg;
    logic [MAG_W-1:0]          x_mag, y_mag;
    logic [COORD_W-1:0]        x_val, y_val;
    logic                      neg_x, neg_y;

    // The result register is free when empty or being taken this cycle.
    assign pop = q_status.not_empty && (!out_valid_reg || out_ready);

    assign neg_x = (head_rec.quadrant == QUAD_TWO) || (head_rec.quadrant == QUAD_THREE);
    assign neg_y = (head_rec.quadrant == QUAD_THREE) || (head_rec.quadrant == QUAD_FOUR);

    assign x_mag = MAG_W'(head_rec.x_whole) * COORD_SCALE + MAG_W'(head_rec.x_frac);
    assign y_mag = MAG_W'(head_rec.y_whole) * COORD_SCALE + MAG_W'(head_rec.y_frac);
    assign x_val = neg_x ? (COORD_W'(0) - {1'b0, x_mag}) : {1'b0, x_mag};
    assign y_val = neg_y ? (COORD_W'(0) - {1'b0, y_mag}) : {1'b0, y_mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pop)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            plate_reg  <= head_rec.plate_colour;
            bottle_reg <= head_rec.bottle_colour;
            status_reg <= head_rec.status_code;
            quad_reg   <= head_rec.quadrant;
            x_reg      <= signed'(x_val);
            y_reg      <= signed'(y_val);
        end
    end

    assign out_valid     = out_valid_reg;
    assign plate_colour  = plate_reg;
    assign bottle_colour = bottle_reg;
    assign status_code   = status_reg;
    assign quadrant      = quad_reg;
    assign x_position    = x_reg;
    assign y_position    = y_reg;

    `ASSERT_NEXT(a_pop_fills_output, clk, rst_n, pop, out_valid_reg)

endmodule

// ----- src/fixed_frame_coordinate_parser.sv -----
// Top level of the fixed frame coordinate parser.
// Depends on ffcp_pkg, ffcp_front, ffcp_queue and ffcp_back.
//
// Usage:
//   Input channel: one received byte per transaction (rx_byte, in_valid,
//   in_ready). Bytes form 11-byte frames: ten body bytes, then a trailer.
//   A frame with trailer 0xFF and header 0xAA 0xBB produces one result
//   transaction on the output channel (four flag bytes, x_position and
//   y_position in hundredths of a cm, signed by quadrant). Other frames
//   are dropped silently and the next byte starts a new frame.
//   Throughput: one byte per cycle. Body bytes are always accepted; the
//   trailer byte is accepted whenever the frame queue has a free slot.
//   Result path: a good frame is written into the queue when its trailer
//   is accepted, and the coordinate multiply-add stands between the queue
//   head and the output register, which raises out_valid when it is free.
//   When the receiver stalls, results wait in the output register and the
//   frame queue (QUEUE_DEPTH entries); only when both are full is the
//   trailer byte held off with in_ready low.
//   Reset clears the byte position, the queue and the output valid.
module fixed_frame_coordinate_parser #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ffcp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                         in_valid,
    output logic                         in_ready,
    output logic [ffcp_pkg::BYTE_W-1:0]  plate_colour,
    output logic [ffcp_pkg::BYTE_W-1:0]  bottle_colour,
    output logic [ffcp_pkg::BYTE_W-1:0]  status_code,
    output logic [ffcp_pkg::BYTE_W-1:0]  quadrant,
    output logic signed [ffcp_pkg::COORD_W-1:0] x_position,
    output logic signed [ffcp_pkg::COORD_W-1:0] y_position,
    output logic                         out_valid,
    input  logic                         out_ready
);
    import ffcp_pkg::*;

    q_status_t  q_status;
    frame_rec_t push_rec;
    frame_rec_t head_rec;
    logic       push;
    logic       pop;

    ffcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_byte  (rx_byte),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    ffcp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .status   (q_status)
    );

    ffcp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_rec      (head_rec),
        .q_status      (q_status),
        .pop           (pop),
        .plate_colour  (plate_colour),
        .bottle_colour (bottle_colour),
        .status_code   (status_code),
        .quadrant      (quadrant),
        .x_position    (x_position),
        .y_position    (y_position),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

endmodule
